// ===== hw/rtl/parcor_to_lpc_step_up_assert.svh =====
// Assertion macros shared by the step-up recursion checker.
`ifndef PARCOR_TO_LPC_STEP_UP_ASSERT_SVH
`define PARCOR_TO_LPC_STEP_UP_ASSERT_SVH

// Checked out of reset only.
`define P2LPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define P2LPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/p2lpc_pkg.sv =====
// Shared types and constants for the PARCOR to LPC step-up block.
`timescale 1ns / 1ps

package p2lpc_pkg;

    // Width of the order configuration register.
    localparam int ORDER_W = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;       // write incoming coefficient into bank 0
        logic k_capture;     // latch k_i from bank 0 read port A
        logic mac_issue;     // issue one multiply-accumulate read pair
        logic k_write;       // write k_i into the destination bank at index i
        logic wr_bank1;      // destination bank for recursion writes
        logic rd_sel_bank1;  // which bank's read data is consumed this cycle
        logic out_load;      // load the output register
        logic out_last;      // the word being loaded closes the set
    } p2lpc_cmd_t;

endpackage

// ===== hw/rtl/p2lpc_bank.sv =====
// Coefficient bank: one write port, two registered read ports.
`timescale 1ns / 1ps

module p2lpc_bank #(
    parameter int DEPTH  = 33,
    parameter int WIDTH  = 33,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/p2lpc_ctrl.sv =====
// Sequencer for loading, the step-up recursion and the output burst.
`timescale 1ns / 1ps

module p2lpc_ctrl import p2lpc_pkg::*; #(
    parameter int MAX_ORDER = 32,
    parameter int IDX_W     = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ORDER_W-1:0] cfg_data,
    input  logic               pipe_busy,
    output p2lpc_cmd_t         cmd,
    output logic [IDX_W-1:0]   rd_addr_a,
    output logic [IDX_W-1:0]   rd_addr_b,
    output logic [IDX_W-1:0]   wr_addr
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KREAD,
        ST_MAC,
        ST_DRAIN,
        ST_KWRITE,
        ST_ORD,
        ST_OLD
    } state_t;

    state_t             state_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [IDX_W-1:0]   load_cnt_reg;
    logic [IDX_W-1:0]   stage_reg;
    logic [IDX_W-1:0]   m_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               m_valid_reg;

    logic [IDX_W-1:0]   eff;
    logic               in_fire;
    logic               final_bank1;
    logic               last_m;

    always_comb begin
        if (order_reg > ORDER_W'(MAX_ORDER)) begin
            eff = IDX_W'(MAX_ORDER);
        end else begin
            eff = order_reg[IDX_W-1:0];
        end
    end

    assign cfg_ready   = 1'b1;
    assign s_tready    = (state_reg == ST_LOAD);
    assign m_tvalid    = m_valid_reg;
    assign in_fire     = s_tvalid && s_tready;
    // Even orders of two or more finish in bank 1, all others in bank 0.
    assign final_bank1 = (eff > IDX_W'(1)) && !eff[0];
    assign last_m      = (m_reg == stage_reg - IDX_W'(1));

    always_comb begin
        cmd.load_we      = in_fire;
        cmd.k_capture    = (state_reg == ST_MAC) && (m_reg == IDX_W'(1));
        cmd.mac_issue    = (state_reg == ST_MAC);
        cmd.k_write      = (state_reg == ST_KWRITE);
        cmd.wr_bank1     = !stage_reg[0];
        cmd.out_load     = (state_reg == ST_OLD) && (!m_valid_reg || m_tready);
        cmd.out_last     = (out_idx_reg == eff);
        if (state_reg == ST_OLD) begin
            // gain always sits in bank 0
            cmd.rd_sel_bank1 = (out_idx_reg != '0) && final_bank1;
        end else begin
            cmd.rd_sel_bank1 = stage_reg[0];
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_KREAD:      rd_addr_a = stage_reg;
            ST_ORD, ST_OLD: rd_addr_a = out_idx_reg;
            default:       rd_addr_a = m_reg;
        endcase
        rd_addr_b = stage_reg - m_reg;
        wr_addr   = (state_reg == ST_KWRITE) ? stage_reg : load_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            order_reg    <= '0;
            load_cnt_reg <= '0;
            stage_reg    <= '0;
            m_reg        <= '0;
            out_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                order_reg <= cfg_data;
            end

            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD: begin
                    if (in_fire) begin
                        if (load_cnt_reg >= eff) begin
                            load_cnt_reg <= '0;
                            out_idx_reg  <= '0;
                            if (eff > IDX_W'(1)) begin
                                stage_reg <= IDX_W'(2);
                                state_reg <= ST_KREAD;
                            end else begin
                                state_reg <= ST_ORD;
                            end
                        end else begin
                            load_cnt_reg <= load_cnt_reg + IDX_W'(1);
                        end
                    end
                end
                ST_KREAD: begin
                    m_reg     <= IDX_W'(1);
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    if (last_m) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        m_reg <= m_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        state_reg <= ST_KWRITE;
                    end
                end
                ST_KWRITE: begin
                    if (stage_reg == eff) begin
                        out_idx_reg <= '0;
                        state_reg   <= ST_ORD;
                    end else begin
                        stage_reg <= stage_reg + IDX_W'(1);
                        state_reg <= ST_KREAD;
                    end
                end
                ST_ORD: begin
                    state_reg <= ST_OLD;
                end
                ST_OLD: begin
                    if (cmd.out_load) begin
                        if (cmd.out_last) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            out_idx_reg <= out_idx_reg + IDX_W'(1);
                            state_reg   <= ST_ORD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/p2lpc_dp.sv =====
// Datapath: two coefficient banks, one saturating MAC and the output register.
`timescale 1ns / 1ps

module p2lpc_dp import p2lpc_pkg::*; #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 23,
    parameter int IDX_W      = 6,
    parameter int DEPTH      = 33
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  p2lpc_cmd_t            cmd,
    input  logic [IDX_W-1:0]      rd_addr_a,
    input  logic [IDX_W-1:0]      rd_addr_b,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [COEF_WIDTH-1:0] coef_in,
    output logic                  pipe_busy,
    output logic [COEF_WIDTH-1:0] lpc_coef,
    output logic                  last_out,
    output logic                  saturated
);

    localparam int W      = COEF_WIDTH;
    localparam int WORD_W = W + 1;       // coefficient plus saturation mark on top
    localparam int PROD_W = 2 * W;
    localparam int SUM_W  = ((PROD_W - FRAC_BITS > W) ? PROD_W - FRAC_BITS : W) + 1;

    logic [WORD_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic [WORD_W-1:0] word_a, word_b;
    logic [WORD_W-1:0] wr_word, mac_word;
    logic [IDX_W-1:0]  waddr;
    logic              we0, we1;

    logic [W-1:0]             k_reg;
    logic                     v1_reg, v2_reg;
    logic [IDX_W-1:0]         addr1_reg, addr2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [WORD_W-1:0]        prev_reg;

    logic signed [PROD_W-1:0] prod_shift;
    logic signed [SUM_W-1:0]  sum;
    logic                     ovf;
    logic [W-1:0]             mac_res;

    logic [W-1:0] out_data_reg;
    logic         out_last_reg;
    logic         out_sat_reg;

    assign word_a    = cmd.rd_sel_bank1 ? rd1_a : rd0_a;
    assign word_b    = cmd.rd_sel_bank1 ? rd1_b : rd0_b;
    assign pipe_busy = v1_reg || v2_reg;

    // Truncating shift, then add and clamp to the coefficient range.
    always_comb begin
        prod_shift = prod_reg >>> FRAC_BITS;
        sum = $signed(prod_shift[SUM_W-1:0])
            + $signed({{(SUM_W - W){prev_reg[W-1]}}, prev_reg[W-1:0]});
        ovf = (sum[SUM_W-1:W-1] != '0) && (sum[SUM_W-1:W-1] != '1);
        if (ovf) begin
            mac_res = sum[SUM_W-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
        end else begin
            mac_res = sum[W-1:0];
        end
        mac_word = {prev_reg[W] | ovf, mac_res};
    end

    always_comb begin
        if (v2_reg) begin
            wr_word = mac_word;
            waddr   = addr2_reg;
        end else if (cmd.k_write) begin
            wr_word = {1'b0, k_reg};
            waddr   = wr_addr;
        end else begin
            wr_word = {1'b0, coef_in};
            waddr   = wr_addr;
        end
        we0 = cmd.load_we || ((v2_reg || cmd.k_write) && !cmd.wr_bank1);
        we1 = (v2_reg || cmd.k_write) && cmd.wr_bank1;
    end

    p2lpc_bank #(
        .DEPTH  (DEPTH),
        .WIDTH  (WORD_W),
        .ADDR_W (IDX_W)
    ) u_bank0 (
        .aclk    (aclk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wr_word),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    p2lpc_bank #(
        .DEPTH  (DEPTH),
        .WIDTH  (WORD_W),
        .ADDR_W (IDX_W)
    ) u_bank1 (
        .aclk    (aclk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wr_word),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.k_capture) begin
            k_reg <= rd0_a[W-1:0];   // k_i is still intact in bank 0 when stage i reads it
        end
        addr1_reg <= rd_addr_a;
        addr2_reg <= addr1_reg;
        prod_reg  <= $signed(k_reg) * $signed(word_b[W-1:0]);
        prev_reg  <= word_a;
        if (cmd.out_load) begin
            out_data_reg <= word_a[W-1:0];
            out_sat_reg  <= word_a[W];
            out_last_reg <= cmd.out_last;
        end
    end

    assign lpc_coef  = out_data_reg;
    assign last_out  = out_last_reg;
    assign saturated = out_sat_reg;

endmodule

// ===== hw/rtl/parcor_to_lpc_step_up.sv =====
// Top level of the PARCOR to LPC step-up recursion block.
`timescale 1ns / 1ps

// Converts a gain and reflection coefficients k1..kM into linear prediction
// coefficients. Write the order M on the cfg channel while the block is idle
// (values above MAX_ORDER act as MAX_ORDER), then stream M+1 input
// transactions: the gain, then k1..kM, signed fixed point with FRAC_BITS
// fraction bits. Once the last one is taken the block runs the recursion
// a_i[m] = a_{i-1}[m] + k_i*a_{i-1}[i-m] on a single multiply-accumulate
// unit, one product per cycle, and returns M+1 output transactions: the gain
// unchanged, then a1..aM, with tlast on aM. Products are truncated towards
// minus infinity; an overflowing sum clamps to the coefficient range and
// tuser marks any coefficient that clamped at some stage. With M = 0 every
// input returns the gain alone, tlast set.
// Sequence: coefficients load back to back, each recursion stage i runs one
// k fetch, i-1 MAC issues, a drain of the MAC pipeline and one write of k_i,
// and each result is read from the bank in ST_ORD and loaded into the output
// register in ST_OLD. Input is not taken while the recursion or the output
// burst runs, but a new frame may load while the final result still waits in
// the output register.

module parcor_to_lpc_step_up import p2lpc_pkg::*; #(
    parameter int MAX_ORDER  = 32,
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 23,
    localparam int TDATA_W   = ((COEF_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input coefficients
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [COEF_WIDTH-1:0] coef_in
    // prediction coefficients
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [COEF_WIDTH-1:0] lpc_coef
    output logic               m_axis_tlast,   // last_out
    output logic               m_axis_tuser,   // [0] saturated
    // order register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ORDER_W-1:0] cfg_data
);

    // Banks hold indices 0..MAX_ORDER.
    localparam int DEPTH = MAX_ORDER + 1;
    localparam int IDX_W = $clog2(DEPTH);

    p2lpc_cmd_t              cmd;
    logic [IDX_W-1:0]        rd_addr_a;
    logic [IDX_W-1:0]        rd_addr_b;
    logic [IDX_W-1:0]        wr_addr;
    logic                    pipe_busy;
    logic [COEF_WIDTH-1:0]   lpc_coef;

    p2lpc_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pipe_busy (pipe_busy),
        .cmd       (cmd),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr)
    );

    p2lpc_dp #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .IDX_W      (IDX_W),
        .DEPTH      (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr),
        .coef_in   (s_axis_tdata[COEF_WIDTH-1:0]),
        .pipe_busy (pipe_busy),
        .lpc_coef  (lpc_coef),
        .last_out  (m_axis_tlast),
        .saturated (m_axis_tuser)
    );

    // pad bits above the coefficient are zero
    assign m_axis_tdata = TDATA_W'(lpc_coef);

endmodule

// ===== hw/rtl/p2lpc_checker.sv =====
// Port-level checks for the step-up block, bound to the top level.
`timescale 1ns / 1ps
`include "parcor_to_lpc_step_up_assert.svh"

module p2lpc_checker #(
    parameter int TDATA_W = 32
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast,
    input logic               m_axis_tuser
);

    // a stalled result stays offered
    `P2LPC_ASSERT(a_out_valid_held, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result withdrawn while stalled")

    // and does not change
    `P2LPC_ASSERT(a_out_payload_held, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

    // no input taken while a burst is still being emitted
    `P2LPC_ASSERT(a_no_load_mid_burst, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input ready during output burst")

    // the final coefficient is k_M passed through, so it never clamps
    `P2LPC_ASSERT(a_last_not_saturated, m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser, "saturation flag on final coefficient")

    // reset empties the output register
    `P2LPC_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind parcor_to_lpc_step_up p2lpc_checker #(.TDATA_W(TDATA_W)) u_p2lpc_checker (.*);

// ===== tb/sv/tb_parcor_to_lpc_step_up.sv =====
// Self-checking testbench for the PARCOR to LPC step-up recursion block.
`timescale 1ns / 1ps

// Frames of order+1 coefficients (gain, then k1..kM) go in on the slave
// stream. A predictor runs the step-up recursion on every completed frame
// and queues the expected LPC words. The monitor checks each output
// transaction against the oldest of them. The order register is only
// written while the block is idle.
module tb_parcor_to_lpc_step_up import p2lpc_pkg::*;;

    localparam int MAX_ORD       = 32;
    localparam int FRAC          = 23;
    localparam int ITEMS         = 330;
    localparam int SETTLE_CYCLES = 40;    // spare cycles before an order write
    localparam int TAIL_CYCLES   = 80;    // watch for stray results at the end
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam longint COEF_MAX  = 64'sd2147483647;
    localparam longint COEF_MIN  = -64'sd2147483648;

    typedef struct {
        logic [31:0] coef;
        bit          last;
        bit          sat;
    } lpc_word_t;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata  = '0;   // [31:0] coef_in
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;         // [31:0] lpc_coef
    logic               m_axis_tlast;         // last_out
    logic               m_axis_tuser;         // [0] saturated
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [ORDER_W-1:0] cfg_data      = '0;

    // stimulus side
    logic [31:0] coef_pending [$];
    int          coefs_queued = 0;
    bit          idle_en      = 1'b1;
    bit          hold_armed   = 1'b0;
    bit          long_hold    = 1'b0;
    int          tx_gap       = 0;
    int          rx_stall     = 0;

    // monitor and predictor side
    lpc_word_t          lpc_expected [$];
    int                 words_due    = 0;
    int                 coefs_taken  = 0;
    int                 order_writes = 0;
    int                 mismatches   = 0;
    bit                 coef_taken   = 1'b0;
    logic [ORDER_W-1:0] order_shadow = '0;
    longint             refl_coef [0:MAX_ORD];
    int                 load_cnt     = 0;

    parcor_to_lpc_step_up u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // Takes one coefficient into the frame. On the coefficient that closes
    // the frame, runs the step-up recursion and queues the M+1 LPC words.
    task automatic absorb_coefficient(input logic [31:0] coef);
        int     eff;
        longint prev_stage [0:MAX_ORD];
        longint cur_stage  [0:MAX_ORD];
        bit     sat_mark   [0:MAX_ORD];
        longint prod;
        longint acc;
        lpc_word_t w;
        eff = (order_shadow > MAX_ORD) ? MAX_ORD : int'(order_shadow);
        if (load_cnt > MAX_ORD) load_cnt = 0;
        refl_coef[load_cnt] = longint'($signed(coef));
        if (load_cnt < eff) begin
            load_cnt++;
            return;
        end
        load_cnt = 0;

        for (int m = 0; m <= MAX_ORD; m++) begin
            sat_mark[m]   = 1'b0;
            prev_stage[m] = 0;
            cur_stage[m]  = 0;
        end
        cur_stage[0] = refl_coef[0];
        for (int m = 1; m < eff; m++) begin
            prev_stage[m] = refl_coef[m];
            cur_stage[m]  = refl_coef[m];
        end
        for (int i = 2; i <= eff; i++) begin
            for (int m = 1; m < i; m++) begin
                // product truncated towards minus infinity, sum clamped
                prod = (refl_coef[i] * prev_stage[i-m]) >>> FRAC;
                acc  = prev_stage[m] + prod;
                if (acc > COEF_MAX) begin
                    acc = COEF_MAX;
                    sat_mark[m] = 1'b1;
                end else if (acc < COEF_MIN) begin
                    acc = COEF_MIN;
                    sat_mark[m] = 1'b1;
                end
                cur_stage[m] = acc;
            end
            for (int m = 1; m < i; m++) prev_stage[m] = cur_stage[m];
        end
        if (eff > 0) cur_stage[eff] = refl_coef[eff];

        for (int m = 0; m <= eff; m++) begin
            w.coef = cur_stage[m][31:0];
            w.last = (m == eff);
            w.sat  = sat_mark[m];
            lpc_expected.push_back(w);
            words_due++;
        end
    endtask

    // Monitor: every handshake is sampled here at the rising edge.
    always @(posedge aclk) begin
        lpc_word_t want;
        coef_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                order_shadow = cfg_data;
                order_writes++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                coef_taken = 1'b1;
                coefs_taken++;
                absorb_coefficient(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (words_due == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", m_axis_tdata));
                end else begin
                    want = lpc_expected.pop_front();
                    words_due--;
                    if (m_axis_tdata !== want.coef)
                        report_mismatch($sformatf("lpc_coef %h, expected %h",
                                                  m_axis_tdata, want.coef));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, expected %b (coef %h)",
                                                  m_axis_tlast, want.last, want.coef));
                    if (m_axis_tuser !== want.sat)
                        report_mismatch($sformatf("saturated %b, expected %b (coef %h)",
                                                  m_axis_tuser, want.sat, want.coef));
                end
            end
        end
    end

    // Driver: presents the next pending coefficient at the falling edge once
    // the previous transaction has gone, with random bursts of idle cycles.
    always @(negedge aclk) begin
        logic        nxt_valid;
        logic [31:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_axis_tvalid || coef_taken) begin
            nxt_valid = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (coef_pending.size() != 0) begin
                if (idle_en && $urandom_range(0, 4) == 0) begin
                    tx_gap = $urandom_range(0, 12);
                end else begin
                    nxt_data  = coef_pending.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // Receiver: random stall bursts, plus the long hold-off below.
    always @(negedge aclk) begin
        logic rdy;
        if (!aresetn || long_hold) begin
            rdy = 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            rdy = 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rx_stall = $urandom_range(0, 12);
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        m_axis_tready <= rdy;
    end

    // Long hold-off: the output backs up, the output burst stalls and the
    // block stops taking coefficients while the driver keeps offering.
    initial begin
        wait (hold_armed);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    initial begin
        #400000;
        $display("parcor_to_lpc_step_up test failed");
        $finish;
    end

    function automatic logic [31:0] pick_coef();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: return $urandom;
            // |k| below one in Q8.23: the usual stable filter
            default: return 32'($urandom_range(0, 32'h00FF_FFFE)) - 32'h007F_FFFF;
        endcase
    endfunction

    task automatic queue_coef(input logic [31:0] coef);
        coef_pending.push_back(coef);
        coefs_queued++;
    endtask

    task automatic queue_frame(input int order);
        queue_coef($urandom);
        for (int k = 0; k < order; k++) queue_coef(pick_coef());
    endtask

    // Waits until every coefficient is taken and every result has come,
    // lets the block settle, then writes the order register.
    task automatic program_order(input logic [ORDER_W-1:0] value);
        int seen;
        wait (coefs_taken == coefs_queued);
        wait (words_due == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        seen = order_writes;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        wait (order_writes != seen);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [ORDER_W-1:0] forced_order [0:3];
        logic [ORDER_W-1:0] nxt_order;
        int phase;
        int eff;
        int frames;
        int sel;
        forced_order = '{6'd3, 6'd32, 6'd63, 6'd33};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // order zero: every coefficient is a frame of its own
        program_order(6'd0);
        queue_coef(32'h7FFF_FFFF);
        queue_coef(32'h8000_0000);
        queue_coef(32'h0000_0000);
        queue_coef(32'hFFFF_FFFF);

        // order one: gain and k1 pass straight through
        program_order(6'd1);
        queue_coef(32'h8000_0000);
        queue_coef(32'h8000_0000);

        // order two: positive and negative clamping of a1, then a tiny
        // negative product that truncates down to minus one LSB
        program_order(6'd2);
        queue_coef(32'h0000_0000);
        queue_coef(32'h7FFF_FFFF);
        queue_coef(32'h7FFF_FFFF);
        queue_coef(32'h7FFF_FFFF);
        queue_coef(32'h8000_0000);
        queue_coef(32'h7FFF_FFFF);
        queue_coef(32'h0000_0000);
        queue_coef(32'h0000_0001);
        queue_coef(32'hFFFF_FFFF);

        // order lowered mid-frame: next coefficient closes the frame
        program_order(6'd3);
        queue_coef(32'h0040_0000);
        queue_coef(32'h0020_0000);
        queue_coef(32'hFFE0_0000);
        program_order(6'd1);
        queue_coef(32'h0010_0000);

        // order raised mid-frame: the frame runs on to the new length
        queue_coef(32'h0080_0000);
        program_order(6'd2);
        queue_coef(32'hFFC0_0000);
        queue_coef(32'h0060_0000);

        // random phases, the first few at fixed orders
        phase = 0;
        while (coefs_queued < ITEMS) begin
            // now and then leave a frame unfinished before the order changes
            eff = (order_shadow > MAX_ORD) ? MAX_ORD : int'(order_shadow);
            if (phase > 0 && eff > 0 && $urandom_range(0, 4) == 0) begin
                frames = $urandom_range(1, eff);
                for (int k = 0; k < frames; k++) queue_coef(pick_coef());
            end

            if (phase < 4) begin
                nxt_order = forced_order[phase];
            end else begin
                sel = $urandom_range(0, 19);
                if (sel == 0)      nxt_order = ORDER_W'($urandom_range(33, 63));
                else if (sel == 1) nxt_order = 6'd32;
                else if (sel < 5)  nxt_order = ORDER_W'($urandom_range(9, 31));
                else               nxt_order = ORDER_W'($urandom_range(0, 8));
            end
            program_order(nxt_order);
            idle_en <= (phase % 4 != 3) && (coefs_queued < ITEMS - 50);

            // close any frame left open, so that the phase stays aligned
            eff = (nxt_order > MAX_ORD) ? MAX_ORD : int'(nxt_order);
            if (load_cnt != 0) begin
                frames = (load_cnt >= eff) ? 1 : eff - load_cnt + 1;
                for (int k = 0; k < frames; k++) queue_coef(pick_coef());
            end

            if (phase == 0) begin
                for (int f = 0; f < 8; f++) queue_frame(eff);
                hold_armed = 1'b1;
            end else begin
                frames = (eff > 8) ? 1 : $urandom_range(2, 6);
                for (int f = 0; f < frames; f++) queue_frame(eff);
            end
            phase++;
        end

        // final stretch runs without idle cycles on either side
        idle_en <= 1'b0;
        wait (coefs_taken == coefs_queued);
        wait (words_due == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("parcor_to_lpc_step_up test passed");
        end else begin
            $display("parcor_to_lpc_step_up test failed");
        end
        $finish;
    end

endmodule
